// ----- src/xzcn_pkg.sv -----
// ----------------------------------------------------------------------------
// xzcn_pkg: shared types and constants
// Fixed widths of the normalized datapath and the control word that travels
// down the pipeline next to each item.
// ----------------------------------------------------------------------------
package xzcn_pkg;

   // normalized magnitudes stay below 2^NORM_BITS
   localparam int NORM_BITS  = 24;
   // a*a + b*b
   localparam int SQ_BITS    = 2 * NORM_BITS + 1;
   // floor(sqrt) of SQ_BITS bits
   localparam int ROOT_BITS  = NORM_BITS + 1;
   // working width of the root register inside the sqrt cells
   localparam int RREG_BITS  = SQ_BITS + 1;
   // one cell per root bit
   localparam int SQRT_STEPS = ROOT_BITS;
   // offsets at or above this magnitude never fall under the threshold
   localparam int SHORT_LIMIT = 256;
   localparam int CFG_BITS   = 16;

   // command codes
   localparam logic [1:0] CMD_SPHERE = 2'd0;
   localparam logic [1:0] CMD_BOX    = 2'd1;

   typedef struct packed {
      logic valid;
      logic found;
      logic neg_x;
      logic neg_z;
   } ctl_type;

   typedef struct packed {
      ctl_type               ctl;
      logic [NORM_BITS-1:0]  a;
      logic [NORM_BITS-1:0]  b;
   } sq_pay_type;

endpackage

// ----- src/xz_collision_normal.sv -----
// ----------------------------------------------------------------------------
// xz_collision_normal: horizontal contact normal, sphere vs sphere or box
// Top level: settings register, front stages, sqrt and divide cell rows.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the req_ fields; an item is taken on every edge where
//   start is high and busy is low. busy stays low, so an item may enter
//   every cycle and many items are in flight at once.
//   Each item yields one result, shown on the rsp_ ports for one cycle with
//   rsp_valid high; the receiver must take it then, it cannot stall.
//   The path runs through six front stages (bounds, offset, magnitude,
//   scaling, squares, sum), 25 square root cells, one numerator stage,
//   NORMAL_FRAC_BITS + 1 divide cells and the output register. Throughput
//   is one item per cycle.
//   min_length_sq is written over the csr_ channel (csr_ready always high)
//   by the user only while no item is in flight; the block does not enforce
//   it. Reset empties the pipeline and sets min_length_sq to 1; no clearing
//   pass is needed. rsp_found is low, with zero normals, for unsupported
//   shapes, for offsets shorter than the threshold and for a zero offset.
// ----------------------------------------------------------------------------
module xz_collision_normal #(
   parameter int COORD_BITS       = 32,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_cmd,
   input  logic signed [COORD_BITS-1:0]          req_sphere_x,
   input  logic signed [COORD_BITS-1:0]          req_sphere_z,
   input  logic signed [COORD_BITS-1:0]          req_other_x,
   input  logic signed [COORD_BITS-1:0]          req_other_z,
   input  logic [COORD_BITS-2:0]                 req_extent_x,
   input  logic [COORD_BITS-2:0]                 req_extent_z,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic signed [NORMAL_FRAC_BITS+1:0]    rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0]    rsp_normal_z,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [xzcn_pkg::CFG_BITS-1:0]         csr_data
);

   localparam int F   = NORMAL_FRAC_BITS;
   localparam int NB  = xzcn_pkg::NORM_BITS;
   localparam int LB  = xzcn_pkg::ROOT_BITS;
   localparam int NW  = NB + F + 1;
   localparam int OW  = F + 2;
   localparam int NSQ = xzcn_pkg::SQRT_STEPS;

   // settings register
   logic [xzcn_pkg::CFG_BITS-1:0] min_len_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= xzcn_pkg::CFG_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         min_len_ff <= csr_data;
      end
   end

   // front stages
   xzcn_pkg::sq_pay_type              sq_pay  [0:NSQ];
   logic [xzcn_pkg::SQ_BITS-1:0]      sq_rem  [0:NSQ];
   logic [xzcn_pkg::RREG_BITS-1:0]    sq_root [0:NSQ];

   xzcn_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start && !busy),
      .cmd           (req_cmd),
      .sphere_x      (req_sphere_x),
      .sphere_z      (req_sphere_z),
      .other_x       (req_other_x),
      .other_z       (req_other_z),
      .extent_x      (req_extent_x),
      .extent_z      (req_extent_z),
      .min_length_sq (min_len_ff),
      .pay_out       (sq_pay[0]),
      .sum_out       (sq_rem[0])
   );

   assign sq_root[0] = '0;

   // square root cell row
   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      xzcn_sqrt_cell #(
         .STEP (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .pay_in   (sq_pay[g]),
         .rem_in   (sq_rem[g]),
         .root_in  (sq_root[g]),
         .pay_out  (sq_pay[g+1]),
         .rem_out  (sq_rem[g+1]),
         .root_out (sq_root[g+1])
      );
   end

   // numerator stage: a * 2^F + floor(L / 2)
   logic [LB-1:0]       len;
   xzcn_pkg::ctl_type   dv_ctl [0:F+1];
   logic [LB-1:0]       dv_len [0:F+1];
   logic [NW-1:0]       dv_nx  [0:F+1];
   logic [NW-1:0]       dv_nz  [0:F+1];
   logic [LB-1:0]       dv_rx  [0:F+1];
   logic [LB-1:0]       dv_rz  [0:F+1];
   logic [F:0]          dv_qx  [0:F+1];
   logic [F:0]          dv_qz  [0:F+1];
   xzcn_pkg::ctl_type   pc_ff;
   logic [LB-1:0]       plen_ff;
   logic [NW-1:0]       pnx_ff, pnz_ff, pnx_in, pnz_in;

   assign len    = sq_root[NSQ][LB-1:0];
   assign pnx_in = {1'b0, sq_pay[NSQ].a, F'(0)} + NW'(len >> 1);
   assign pnz_in = {1'b0, sq_pay[NSQ].b, F'(0)} + NW'(len >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff.valid <= 1'b0;
      end else begin
         pc_ff <= sq_pay[NSQ].ctl;
      end
   end

   always_ff @(posedge clock) begin
      plen_ff <= len;
      pnx_ff  <= pnx_in;
      pnz_ff  <= pnz_in;
   end

   assign dv_ctl[0] = pc_ff;
   assign dv_len[0] = plen_ff;
   assign dv_nx[0]  = pnx_ff;
   assign dv_nz[0]  = pnz_ff;
   assign dv_rx[0]  = LB'(pnx_ff[NW-1:F+1]);
   assign dv_rz[0]  = LB'(pnz_ff[NW-1:F+1]);
   assign dv_qx[0]  = '0;
   assign dv_qz[0]  = '0;

   // divide cell row, one quotient bit per cell
   for (genvar g = 0; g <= F; g++) begin : g_div
      xzcn_div_cell #(
         .FRAC (F),
         .STEP (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (dv_ctl[g]),
         .len_in  (dv_len[g]),
         .nx_in   (dv_nx[g]),
         .nz_in   (dv_nz[g]),
         .rx_in   (dv_rx[g]),
         .rz_in   (dv_rz[g]),
         .qx_in   (dv_qx[g]),
         .qz_in   (dv_qz[g]),
         .ctl_out (dv_ctl[g+1]),
         .len_out (dv_len[g+1]),
         .nx_out  (dv_nx[g+1]),
         .nz_out  (dv_nz[g+1]),
         .rx_out  (dv_rx[g+1]),
         .rz_out  (dv_rz[g+1]),
         .qx_out  (dv_qx[g+1]),
         .qz_out  (dv_qz[g+1])
      );
   end

   // output register: apply signs, zero when no normal
   xzcn_pkg::ctl_type   oc;
   logic                ovalid_ff, ofound_ff;
   logic [OW-1:0]       ox_ff, oz_ff, qxe, qze;

   assign oc  = dv_ctl[F+1];
   assign qxe = OW'(dv_qx[F+1]);
   assign qze = OW'(dv_qz[F+1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
         ofound_ff <= 1'b0;
      end else begin
         ovalid_ff <= oc.valid;
         ofound_ff <= oc.valid && oc.found;
      end
   end

   always_ff @(posedge clock) begin
      if (oc.found) begin
         ox_ff <= oc.neg_x ? -qxe : qxe;
         oz_ff <= oc.neg_z ? -qze : qze;
      end else begin
         ox_ff <= '0;
         oz_ff <= '0;
      end
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_found    = ofound_ff;
   assign rsp_normal_x = $signed(ox_ff);
   assign rsp_normal_z = $signed(oz_ff);

   // checks
   localparam logic signed [OW-1:0] UNIT = OW'(1) << F;

   a_found_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> rsp_valid)
      else $error("found without result strobe");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_normal_x == '0 && rsp_normal_z == '0)
      else $error("nonzero normal without a hit");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> rsp_normal_x <= UNIT && rsp_normal_x >= -UNIT
                 && rsp_normal_z <= UNIT && rsp_normal_z >= -UNIT)
      else $error("normal component out of unit range");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> rsp_normal_x != '0 || rsp_normal_z != '0)
      else $error("hit with zero normal");

endmodule

// ----- src/xzcn_front.sv -----
// ----------------------------------------------------------------------------
// xzcn_front: offset, threshold and normalization stages
// Clamps into the box, forms the XZ offset, flags short or unsupported
// items, scales magnitudes below 2^24 and forms a*a + b*b. Six stages.
// ----------------------------------------------------------------------------
module xzcn_front #(
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [1:0]                            cmd,
   input  logic signed [COORD_BITS-1:0]          sphere_x,
   input  logic signed [COORD_BITS-1:0]          sphere_z,
   input  logic signed [COORD_BITS-1:0]          other_x,
   input  logic signed [COORD_BITS-1:0]          other_z,
   input  logic [COORD_BITS-2:0]                 extent_x,
   input  logic [COORD_BITS-2:0]                 extent_z,
   input  logic [xzcn_pkg::CFG_BITS-1:0]         min_length_sq,
   output xzcn_pkg::sq_pay_type                  pay_out,
   output logic [xzcn_pkg::SQ_BITS-1:0]          sum_out
);

   localparam int DW   = COORD_BITS + 2;
   localparam int MW   = COORD_BITS + 1;
   localparam int NB   = xzcn_pkg::NORM_BITS;
   localparam int EW   = (MW > NB) ? MW : NB;
   localparam int SMAX = (MW > NB) ? (MW - NB) : 0;
   localparam int SW   = $clog2(SMAX + 2);

   // stage 1: box bounds
   xzcn_pkg::ctl_type          c1_ff, c1_in;
   logic [1:0]                 cmd1_ff;
   logic signed [DW-1:0]       sx1_ff, sz1_ff, ox1_ff, oz1_ff;
   logic signed [DW-1:0]       lox1_ff, hix1_ff, loz1_ff, hiz1_ff;
   logic signed [DW-1:0]       sxe, sze, oxe, oze, exe, eze;

   assign sxe = DW'(sphere_x);
   assign sze = DW'(sphere_z);
   assign oxe = DW'(other_x);
   assign oze = DW'(other_z);
   assign exe = $signed({3'b000, extent_x});
   assign eze = $signed({3'b000, extent_z});

   always_comb begin
      c1_in       = '0;
      c1_in.valid = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
      end else begin
         c1_ff <= c1_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff <= cmd;
      sx1_ff  <= sxe;
      sz1_ff  <= sze;
      ox1_ff  <= oxe;
      oz1_ff  <= oze;
      lox1_ff <= oxe - exe;
      hix1_ff <= oxe + exe;
      loz1_ff <= oze - eze;
      hiz1_ff <= oze + eze;
   end

   // stage 2: closest point and offset
   xzcn_pkg::ctl_type          c2_ff;
   logic                       unsup2_ff;
   logic signed [DW-1:0]       dx2_ff, dz2_ff, px, pz;

   always_comb begin
      if (cmd1_ff == xzcn_pkg::CMD_BOX) begin
         if (sx1_ff > hix1_ff)      px = hix1_ff;
         else if (sx1_ff < lox1_ff) px = lox1_ff;
         else                       px = sx1_ff;
         if (sz1_ff > hiz1_ff)      pz = hiz1_ff;
         else if (sz1_ff < loz1_ff) pz = loz1_ff;
         else                       pz = sz1_ff;
      end else begin
         px = ox1_ff;
         pz = oz1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff.valid <= 1'b0;
      end else begin
         c2_ff <= c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      unsup2_ff <= (cmd1_ff != xzcn_pkg::CMD_SPHERE) && (cmd1_ff != xzcn_pkg::CMD_BOX);
      dx2_ff    <= sx1_ff - px;
      dz2_ff    <= sz1_ff - pz;
   end

   // stage 3: magnitudes and signs
   xzcn_pkg::ctl_type          c3_ff, c3_in;
   logic                       unsup3_ff;
   logic [MW-1:0]              mx3_ff, mz3_ff;
   logic signed [DW-1:0]       ndx, ndz;

   assign ndx = -dx2_ff;
   assign ndz = -dz2_ff;

   always_comb begin
      c3_in       = c2_ff;
      c3_in.neg_x = dx2_ff[DW-1];
      c3_in.neg_z = dz2_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_ff.valid <= 1'b0;
      end else begin
         c3_ff <= c3_in;
      end
   end

   always_ff @(posedge clock) begin
      unsup3_ff <= unsup2_ff;
      mx3_ff    <= dx2_ff[DW-1] ? MW'(ndx) : MW'(dx2_ff);
      mz3_ff    <= dz2_ff[DW-1] ? MW'(ndz) : MW'(dz2_ff);
   end

   // stage 4: threshold test, common shift, normalized magnitudes
   xzcn_pkg::ctl_type          c4_ff, c4_in;
   logic [NB-1:0]              a4_ff, b4_ff;
   logic [EW-1:0]              mx_ext, mz_ext, mor_ext, ash, bsh;
   logic [SW-1:0]              shamt;
   logic                       hit;
   logic [16:0]                small_sq;
   logic                       short_hit, zero_hit;

   assign mx_ext   = EW'(mx3_ff);
   assign mz_ext   = EW'(mz3_ff);
   assign mor_ext  = mx_ext | mz_ext;
   assign small_sq = 17'(mx3_ff[7:0]) * 17'(mx3_ff[7:0])
                   + 17'(mz3_ff[7:0]) * 17'(mz3_ff[7:0]);
   assign short_hit = (mx3_ff < MW'(xzcn_pkg::SHORT_LIMIT))
                   && (mz3_ff < MW'(xzcn_pkg::SHORT_LIMIT))
                   && (small_sq < 17'(min_length_sq));
   assign zero_hit  = (mx3_ff == '0) && (mz3_ff == '0);

   // smallest shift that brings both magnitudes under 2^24
   always_comb begin
      shamt = '0;
      hit   = 1'b0;
      for (int i = 0; i <= SMAX; i++) begin
         if (!hit && ((mor_ext >> i) >> NB) == '0) begin
            shamt = SW'(i);
            hit   = 1'b1;
         end
      end
   end

   assign ash = mx_ext >> shamt;
   assign bsh = mz_ext >> shamt;

   always_comb begin
      c4_in       = c3_ff;
      c4_in.found = !(unsup3_ff || short_hit || zero_hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_ff.valid <= 1'b0;
      end else begin
         c4_ff <= c4_in;
      end
   end

   always_ff @(posedge clock) begin
      a4_ff <= ash[NB-1:0];
      b4_ff <= bsh[NB-1:0];
   end

   // stage 5: squares
   xzcn_pkg::sq_pay_type       p5_ff;
   logic [2*NB-1:0]            asq5_ff, bsq5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_ff.ctl.valid <= 1'b0;
      end else begin
         p5_ff.ctl <= c4_ff;
      end
      p5_ff.a <= a4_ff;
      p5_ff.b <= b4_ff;
   end

   always_ff @(posedge clock) begin
      asq5_ff <= a4_ff * a4_ff;
      bsq5_ff <= b4_ff * b4_ff;
   end

   // stage 6: sum of squares
   xzcn_pkg::sq_pay_type       p6_ff;
   logic [xzcn_pkg::SQ_BITS-1:0] sum6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_ff.ctl.valid <= 1'b0;
      end else begin
         p6_ff.ctl <= p5_ff.ctl;
      end
      p6_ff.a <= p5_ff.a;
      p6_ff.b <= p5_ff.b;
   end

   always_ff @(posedge clock) begin
      sum6_ff <= xzcn_pkg::SQ_BITS'(asq5_ff) + xzcn_pkg::SQ_BITS'(bsq5_ff);
   end

   assign pay_out = p6_ff;
   assign sum_out = sum6_ff;

endmodule

// ----- src/xzcn_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// xzcn_sqrt_cell: one digit of the integer square root
// Restoring digit-by-digit step for one root bit; the item moves on to the
// next cell every cycle together with its payload.
// ----------------------------------------------------------------------------
module xzcn_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  xzcn_pkg::sq_pay_type                  pay_in,
   input  logic [xzcn_pkg::SQ_BITS-1:0]          rem_in,
   input  logic [xzcn_pkg::RREG_BITS-1:0]        root_in,
   output xzcn_pkg::sq_pay_type                  pay_out,
   output logic [xzcn_pkg::SQ_BITS-1:0]          rem_out,
   output logic [xzcn_pkg::RREG_BITS-1:0]        root_out
);

   localparam int RB = xzcn_pkg::RREG_BITS;
   localparam logic [RB-1:0] BIT = RB'(1) << (xzcn_pkg::SQ_BITS - 1 - 2 * STEP);

   xzcn_pkg::sq_pay_type            pay_ff;
   logic [xzcn_pkg::SQ_BITS-1:0]    rem_ff, rem_in_nx;
   logic [RB-1:0]                   root_ff, root_nx, trial;
   logic                            take;

   // trial subtract of root + bit
   assign trial = root_in + BIT;
   assign take  = RB'(rem_in) >= trial;

   always_comb begin
      if (take) begin
         rem_in_nx = rem_in - xzcn_pkg::SQ_BITS'(trial);
         root_nx   = (root_in >> 1) + BIT;
      end else begin
         rem_in_nx = rem_in;
         root_nx   = root_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pay_ff.ctl.valid <= 1'b0;
      end else begin
         pay_ff.ctl <= pay_in.ctl;
      end
      pay_ff.a <= pay_in.a;
      pay_ff.b <= pay_in.b;
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in_nx;
      root_ff  <= root_nx;
   end

   assign pay_out  = pay_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

// ----- src/xzcn_div_cell.sv -----
// ----------------------------------------------------------------------------
// xzcn_div_cell: one quotient bit for both normal components
// Restoring division step: shift in the next numerator bit, subtract the
// length when it fits, append the quotient bit.
// ----------------------------------------------------------------------------
module xzcn_div_cell #(
   parameter int FRAC = 14,
   parameter int STEP = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  xzcn_pkg::ctl_type                     ctl_in,
   input  logic [xzcn_pkg::ROOT_BITS-1:0]        len_in,
   input  logic [xzcn_pkg::NORM_BITS+FRAC:0]     nx_in,
   input  logic [xzcn_pkg::NORM_BITS+FRAC:0]     nz_in,
   input  logic [xzcn_pkg::ROOT_BITS-1:0]        rx_in,
   input  logic [xzcn_pkg::ROOT_BITS-1:0]        rz_in,
   input  logic [FRAC:0]                         qx_in,
   input  logic [FRAC:0]                         qz_in,
   output xzcn_pkg::ctl_type                     ctl_out,
   output logic [xzcn_pkg::ROOT_BITS-1:0]        len_out,
   output logic [xzcn_pkg::NORM_BITS+FRAC:0]     nx_out,
   output logic [xzcn_pkg::NORM_BITS+FRAC:0]     nz_out,
   output logic [xzcn_pkg::ROOT_BITS-1:0]        rx_out,
   output logic [xzcn_pkg::ROOT_BITS-1:0]        rz_out,
   output logic [FRAC:0]                         qx_out,
   output logic [FRAC:0]                         qz_out
);

   localparam int LB = xzcn_pkg::ROOT_BITS;
   localparam int NW = xzcn_pkg::NORM_BITS + FRAC + 1;

   xzcn_pkg::ctl_type     ctl_ff;
   logic [LB-1:0]         len_ff, rx_ff, rz_ff;
   logic [NW-1:0]         nx_ff, nz_ff;
   logic [FRAC:0]         qx_ff, qz_ff;
   logic [LB:0]           rx2, rz2, lext, rxs, rzs;
   logic                  gx, gz;

   assign lext = {1'b0, len_in};
   assign rx2  = {rx_in, nx_in[FRAC-STEP]};
   assign rz2  = {rz_in, nz_in[FRAC-STEP]};
   assign gx   = rx2 >= lext;
   assign gz   = rz2 >= lext;
   assign rxs  = gx ? (rx2 - lext) : rx2;
   assign rzs  = gz ? (rz2 - lext) : rz2;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      nx_ff  <= nx_in;
      nz_ff  <= nz_in;
      rx_ff  <= rxs[LB-1:0];
      rz_ff  <= rzs[LB-1:0];
      qx_ff  <= {qx_in[FRAC-1:0], gx};
      qz_ff  <= {qz_in[FRAC-1:0], gz};
   end

   assign ctl_out = ctl_ff;
   assign len_out = len_ff;
   assign nx_out  = nx_ff;
   assign nz_out  = nz_ff;
   assign rx_out  = rx_ff;
   assign rz_out  = rz_ff;
   assign qx_out  = qx_ff;
   assign qz_out  = qz_ff;

endmodule

// ----- test/xz_collision_normal_check.sv -----
// ----------------------------------------------------------------------------
// xz_collision_normal_check: contact normal predictor and result checker
// Watches the request, response and settings channels, predicts each item's
// normal from its own copy of min_length_sq, and compares results in order.
// ----------------------------------------------------------------------------
module xz_collision_normal_check #(
   parameter int COORD_BITS       = 32,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_cmd,
   input  logic signed [COORD_BITS-1:0]       req_sphere_x,
   input  logic signed [COORD_BITS-1:0]       req_sphere_z,
   input  logic signed [COORD_BITS-1:0]       req_other_x,
   input  logic signed [COORD_BITS-1:0]       req_other_z,
   input  logic [COORD_BITS-2:0]              req_extent_x,
   input  logic [COORD_BITS-2:0]              req_extent_z,
   input  logic                               rsp_valid,
   input  logic                               rsp_found,
   input  logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   input  logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [xzcn_pkg::CFG_BITS-1:0]      csr_data,
   output int                                 errors,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = NORMAL_FRAC_BITS + 2;

   typedef struct packed {
      logic          found;
      logic [NB-1:0] nx;
      logic [NB-1:0] nz;
   } normal_type;

   normal_type  normals_due[$];
   logic [15:0] min_len_sq;

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic normal_type contact_normal(logic [1:0] cmd, longint sx, longint sz,
                                                 longint ox, longint oz, longint ex,
                                                 longint ez);
      normal_type      r;
      longint          px, pz, dx, dz;
      longint unsigned ax, az, a, b, len, mx, mz;
      int              s;
      r = '0;
      s = 0;
      if (cmd == xzcn_pkg::CMD_SPHERE) begin
         px = ox;
         pz = oz;
      end else if (cmd == xzcn_pkg::CMD_BOX) begin
         px = clamp_to(sx, ox - ex, ox + ex);
         pz = clamp_to(sz, oz - ez, oz + ez);
      end else begin
         return r;
      end
      dx = sx - px;
      dz = sz - pz;
      ax = dx < 0 ? -dx : dx;
      az = dz < 0 ? -dz : dz;
      // short offset, or no direction at all
      if (ax < 256 && az < 256 && ax * ax + az * az < min_len_sq) return r;
      if (ax == 0 && az == 0) return r;
      while (((ax | az) >> s) >= (64'd1 << 24)) s++;
      a = ax >> s;
      b = az >> s;
      len = root_floor(a * a + b * b);
      if (len == 0) return r;
      mx = ((a << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      mz = ((b << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      r.found = 1'b1;
      r.nx = dx < 0 ? NB'(-mx) : NB'(mx);
      r.nz = dz < 0 ? NB'(-mz) : NB'(mz);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   assign pending = normals_due.size();

   // predict on accepted items, check on result strobes
   always @(posedge clock) begin
      normal_type got, want;
      if (reset) begin
         min_len_sq <= 16'd1;
         normals_due.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) min_len_sq <= csr_data;
         if (rsp_valid) begin
            got = {rsp_found, rsp_normal_x, rsp_normal_z};
            if (normals_due.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = normals_due.pop_front();
               if (got.found !== want.found)
                  report_mismatch($sformatf("found %b want %b", got.found, want.found));
               if (got.nx !== want.nx)
                  report_mismatch($sformatf("normal_x %0d want %0d",
                                            $signed(got.nx), $signed(want.nx)));
               if (got.nz !== want.nz)
                  report_mismatch($sformatf("normal_z %0d want %0d",
                                            $signed(got.nz), $signed(want.nz)));
            end
         end
         if (start && !busy)
            normals_due = {normals_due,
                           contact_normal(req_cmd, req_sphere_x, req_sphere_z,
                                          req_other_x, req_other_z,
                                          longint'({1'b0, req_extent_x}),
                                          longint'({1'b0, req_extent_z}))};
      end
   end
endmodule

// ----- test/xz_collision_normal_test.sv -----
// ----------------------------------------------------------------------------
// xz_collision_normal_test: contact normal block testbench
// Directed corner items, then random sphere, box and unsupported items under
// several thresholds, with random start gaps; the checker scores every result.
// ----------------------------------------------------------------------------
module xz_collision_normal_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 48;
   localparam int LIMIT   = 400000;

   logic        clock, reset, start, busy;
   logic [1:0]  req_cmd;
   logic [31:0] req_sphere_x, req_sphere_z, req_other_x, req_other_z;
   logic [30:0] req_extent_x, req_extent_z;
   logic        rsp_valid, rsp_found;
   logic [15:0] rsp_normal_x, rsp_normal_z;
   logic        csr_valid, csr_ready;
   logic [15:0] csr_data;
   int          errors, pending, cycles;
   bit          steady;

   xz_collision_normal uut (.*);
   xz_collision_normal_check chk (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("** xz_collision_normal: FAILED **");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 600)) - 300);
         2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
         default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      endcase
   endfunction

   // start stays high between back-to-back items; it drops only in idle cycles
   task automatic send_item(logic [1:0] cmd, logic [31:0] sx, logic [31:0] sz,
                            logic [31:0] ox, logic [31:0] oz, logic [30:0] ex,
                            logic [30:0] ez);
      while (!steady && $urandom_range(0, 99) < 30) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_sphere_x <= sx;
      req_sphere_z <= sz;
      req_other_x  <= ox;
      req_other_z  <= oz;
      req_extent_x <= ex;
      req_extent_z <= ez;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random();
      logic [31:0] sx, sz;
      logic [1:0]  cmd;
      sx = rand_coord();
      sz = rand_coord();
      cmd = $urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0)
         send_item(cmd, sx, sz, sx + 32'($signed($urandom_range(0, 40)) - 20),
                   sz + 32'($signed($urandom_range(0, 40)) - 20),
                   31'($urandom_range(0, 30)), 31'($urandom_range(0, 30)));
      else
         send_item(cmd, sx, sz, rand_coord(), rand_coord(),
                   $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22)),
                   $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22)));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] thresholds [5];
      thresholds = '{16'd1, 16'd0, 16'hFFFF, 16'd100, 16'd40000};
      reset = 1; start = 0; req_cmd = 0;
      req_sphere_x = 0; req_sphere_z = 0; req_other_x = 0; req_other_z = 0;
      req_extent_x = 0; req_extent_z = 0; csr_valid = 0; csr_data = 0;
      cycles = 0; steady = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, both shapes, unsupported, short and zero offsets
      send_item(xzcn_pkg::CMD_SPHERE, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                '1, '1);
      send_item(xzcn_pkg::CMD_SPHERE, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                32'h7FFFFFFF, 0, 0);
      send_item(xzcn_pkg::CMD_SPHERE, 5, 7, 5, 7, 0, 0);
      send_item(xzcn_pkg::CMD_SPHERE, 1, 0, 0, 0, 0, 0);
      send_item(xzcn_pkg::CMD_SPHERE, 0, 0, 0, 32'hFFFFFFFF, 0, 0);
      send_item(xzcn_pkg::CMD_SPHERE, 255, 255, 0, 0, 0, 0);
      send_item(xzcn_pkg::CMD_SPHERE, 256, 0, 0, 0, 0, 0);
      send_item(xzcn_pkg::CMD_BOX, 100, 100, 0, 0, 50, 50);
      send_item(xzcn_pkg::CMD_BOX, 10, 10, 0, 0, 50, 50);
      send_item(xzcn_pkg::CMD_BOX, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                '1, '1);
      send_item(xzcn_pkg::CMD_BOX, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                0, 0);
      send_item(xzcn_pkg::CMD_BOX, 32'h80000000, 0, 32'h7FFFFFFF, 0, 31'h00010000, '1);
      send_item(2'd2, 1000, 2000, 0, 0, 5, 5);
      send_item(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, '1, '1);
      send_item(xzcn_pkg::CMD_SPHERE, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA,
                32'h55555555, 31'h2AAAAAAA, 31'h55555555);
      drain();

      // random phases across thresholds, one without idle gaps
      foreach (thresholds[p]) begin
         write_threshold(thresholds[p]);
         steady = (p == 3);
         repeat (180) send_random();
         drain();
      end

      if (errors == 0)
         $display("** xz_collision_normal: PASSED **");
      else
         $display("** xz_collision_normal: FAILED **");
      $finish;
   end
endmodule
